// ===== design/cdm_pkg.sv =====
// Shared types and constants for the curvature drive mixer.
package cdm_pkg;

    // Sequencer states, also the datapath operation codes
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_SIN_A     = 5'd1;
    localparam logic [4:0] ST_SIN_X2    = 5'd2;
    localparam logic [4:0] ST_SIN_P1    = 5'd3;
    localparam logic [4:0] ST_SIN_P2    = 5'd4;
    localparam logic [4:0] ST_SIN_P3    = 5'd5;
    localparam logic [4:0] ST_SIN_R     = 5'd6;
    localparam logic [4:0] ST_PASS_MUL  = 5'd7;
    localparam logic [4:0] ST_DIV_LD    = 5'd8;
    localparam logic [4:0] ST_DIV_STEP  = 5'd9;
    localparam logic [4:0] ST_DIV_END   = 5'd10;
    localparam logic [4:0] ST_IN_MUL    = 5'd11;
    localparam logic [4:0] ST_IN_ACC    = 5'd12;
    localparam logic [4:0] ST_IN_HALF   = 5'd13;
    localparam logic [4:0] ST_IN_ADD    = 5'd14;
    localparam logic [4:0] ST_QS_KEEP   = 5'd15;
    localparam logic [4:0] ST_QS_WA     = 5'd16;
    localparam logic [4:0] ST_QS_SC     = 5'd17;
    localparam logic [4:0] ST_QS_SUM    = 5'd18;
    localparam logic [4:0] ST_NT_1      = 5'd19;
    localparam logic [4:0] ST_NT_2      = 5'd20;
    localparam logic [4:0] ST_NT_3      = 5'd21;
    localparam logic [4:0] ST_NT_4      = 5'd22;
    localparam logic [4:0] ST_MIX       = 5'd23;

    // Configuration register indexes
    localparam logic [2:0] CFG_WHEEL_DB   = 3'd0;
    localparam logic [2:0] CFG_THR_DB     = 3'd1;
    localparam logic [2:0] CFG_HI_CURVE   = 3'd2;
    localparam logic [2:0] CFG_LO_CURVE   = 3'd3;
    localparam logic [2:0] CFG_TURN_GAINS = 3'd4;
    localparam logic [2:0] CFG_IN_GAINS   = 3'd5;
    localparam logic [2:0] CFG_IN_THR     = 3'd6;
    localparam logic [2:0] CFG_QS_SET     = 3'd7;

    // Multiplier shift selects
    localparam logic [1:0] SH_15 = 2'd0;
    localparam logic [1:0] SH_11 = 2'd1;
    localparam logic [1:0] SH_1  = 2'd2;

    // Sine polynomial, Q15
    localparam logic signed [17:0] SIN_C1 = 18'sd51466;
    localparam logic signed [17:0] SIN_C3 = 18'sd21077;
    localparam logic signed [17:0] SIN_C5 = 18'sd2383;

    typedef struct packed {
        logic [14:0] wheel_db;
        logic [14:0] thr_db;
        logic [14:0] hi_curve;
        logic [14:0] lo_curve;
        logic [31:0] turn_gains;
        logic [63:0] inertia_gains;
        logic [14:0] inertia_thr;
        logic [47:0] qs_set;
    } t_cfg;

    typedef struct packed {
        logic [4:0] op;
        logic       pass;
        logic       load;
        logic       out_we;
    } t_cmd;

    typedef struct packed {
        logic hg;
        logic qt;
        logic den_zero;
        logic qs_on;
        logic div_last;
    } t_sts;

endpackage

// ===== design/cdm_if.sv =====
// Request channel interfaces for the curvature drive mixer.
interface cdm_in_if #(parameter int SW = 16);
    logic          valid;
    logic          ready;
    logic [SW-1:0] throttle;
    logic [SW-1:0] steer;
    logic          quick_turn;
    logic          high_gear;
    modport source (output valid, throttle, steer, quick_turn, high_gear, input ready);
    modport sink   (input valid, throttle, steer, quick_turn, high_gear, output ready);
endinterface

interface cdm_out_if #(parameter int SW = 16);
    logic          valid;
    logic          ready;
    logic [SW-1:0] left_power;
    logic [SW-1:0] right_power;
    modport source (output valid, left_power, right_power, input ready);
    modport sink   (input valid, left_power, right_power, output ready);
endinterface

interface cdm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/cdm_cfg.sv =====
// Configuration register file.
module cdm_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cdm_cfg_if.sink       i_cfg,
    output cdm_pkg::t_cfg o_cfg
);
    import cdm_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_db      <= 15'd655;
            r_cfg.thr_db        <= 15'd655;
            r_cfg.hi_curve      <= 15'd21299;
            r_cfg.lo_curve      <= 15'd16384;
            r_cfg.turn_gains    <= 32'd1395872563;
            r_cfg.inertia_gains <= 64'd4611747592420737024;
            r_cfg.inertia_thr   <= 15'd21299;
            r_cfg.qs_set        <= 48'd70368958959616;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WHEEL_DB:   r_cfg.wheel_db      <= i_cfg.data[14:0];
                CFG_THR_DB:     r_cfg.thr_db        <= i_cfg.data[14:0];
                CFG_HI_CURVE:   r_cfg.hi_curve      <= i_cfg.data[14:0];
                CFG_LO_CURVE:   r_cfg.lo_curve      <= i_cfg.data[14:0];
                CFG_TURN_GAINS: r_cfg.turn_gains    <= i_cfg.data[31:0];
                CFG_IN_GAINS:   r_cfg.inertia_gains <= i_cfg.data;
                CFG_IN_THR:     r_cfg.inertia_thr   <= i_cfg.data[14:0];
                CFG_QS_SET:     r_cfg.qs_set        <= i_cfg.data[47:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== design/cdm_ctrl.sv =====
// Sequencer for the mixer datapath.
module cdm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  cdm_pkg::t_sts i_sts,
    output cdm_pkg::t_cmd o_cmd
);
    import cdm_pkg::*;

    logic [4:0] r_state, n_state;
    logic       r_pass, n_pass;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_pass       = r_pass;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.op     = r_state;
        o_cmd.pass   = r_pass;
        o_cmd.load   = 1'b0;
        o_cmd.out_we = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SIN_A;
                    n_pass     = 1'b0;
                    n_cnt      = 2'd0;
                end
            end
            ST_SIN_A:  n_state = ST_SIN_X2;
            ST_SIN_X2: n_state = ST_SIN_P1;
            ST_SIN_P1: n_state = ST_SIN_P2;
            ST_SIN_P2: n_state = ST_SIN_P3;
            ST_SIN_P3: n_state = ST_SIN_R;
            ST_SIN_R: begin
                if (r_pass) begin
                    n_state = ST_DIV_LD;
                end else begin
                    n_pass  = 1'b1;
                    n_state = i_sts.den_zero ? ST_IN_MUL : ST_PASS_MUL;
                end
            end
            ST_PASS_MUL: n_state = ST_SIN_A;
            ST_DIV_LD:   n_state = ST_DIV_STEP;
            ST_DIV_STEP: begin
                if (i_sts.div_last) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                n_cnt   = r_cnt + 2'd1;
                n_state = (n_cnt == (i_sts.hg ? 2'd2 : 2'd3)) ? ST_IN_MUL : ST_PASS_MUL;
            end
            ST_IN_MUL:  n_state = ST_IN_ACC;
            ST_IN_ACC:  n_state = ST_IN_HALF;
            ST_IN_HALF: n_state = ST_IN_ADD;
            ST_IN_ADD: begin
                if (i_sts.qt) begin
                    n_state = i_sts.qs_on ? ST_QS_KEEP : ST_MIX;
                end else begin
                    n_state = ST_NT_1;
                end
            end
            ST_QS_KEEP: n_state = ST_QS_WA;
            ST_QS_WA:   n_state = ST_QS_SC;
            ST_QS_SC:   n_state = ST_QS_SUM;
            ST_QS_SUM:  n_state = ST_MIX;
            ST_NT_1:    n_state = ST_NT_2;
            ST_NT_2:    n_state = ST_NT_3;
            ST_NT_3:    n_state = ST_NT_4;
            ST_NT_4:    n_state = ST_MIX;
            ST_MIX: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_we = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b0;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/cdm_dp.sv =====
// Mixer datapath: shared multiplier, serial divider, accumulators, output mix.
module cdm_dp #(
    parameter int SW = 16,
    parameter int AW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cdm_pkg::t_cfg i_cfg,
    input  cdm_pkg::t_cmd i_cmd,
    output cdm_pkg::t_sts o_sts,
    input  logic [SW-1:0] i_throttle,
    input  logic [SW-1:0] i_steer,
    input  logic          i_quick_turn,
    input  logic          i_high_gear,
    output logic [SW-1:0] o_left_power,
    output logic [SW-1:0] o_right_power
);
    import cdm_pkg::*;

    localparam int LW     = (AW + 3 > 23) ? AW + 3 : 23;
    localparam int MW     = LW + 2;
    localparam int IN_UP  = (SW < 16) ? 16 - SW : 0;
    localparam int IN_DN  = (SW > 16) ? SW - 16 : 0;
    localparam logic signed [LW:0] SAT_HI = {{(LW - AW + 2){1'b0}}, {(AW - 1){1'b1}}};
    localparam logic signed [LW:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [LW-1:0] DEC  = LW'(65536);
    localparam logic signed [LW-1:0] ONE  = LW'(32768);
    localparam logic signed [MW-1:0] ONE_M = MW'(32768);
    localparam logic [SW-1:0] MAXP = {1'b0, {(SW - 1){1'b1}}};

    function automatic logic signed [16:0] f_in(input logic [SW-1:0] raw);
        logic          neg;
        logic [SW-1:0] m;
        logic [SW+15:0] e;
        logic signed [16:0] v;
        neg = raw[SW-1];
        m   = neg ? (~raw + 1'b1) : raw;
        e   = ((SW + 16)'(m) << IN_UP) >> IN_DN;
        v   = $signed({1'b0, e[15:0]});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [16:0] f_db(input logic signed [16:0] v,
                                                input logic [14:0] db);
        logic [16:0] m;
        m = v[16] ? 17'(-v) : 17'(v);
        return (m > {2'b0, db}) ? v : 17'sd0;
    endfunction

    function automatic logic [SW-1:0] f_out(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] c;
        logic [16:0]    m;
        logic [SW+16:0] e;
        c = (v > ONE_M) ? ONE_M : ((v < -ONE_M) ? -ONE_M : v);
        m = c[MW-1] ? 17'(-c) : 17'(c);
        e = ((SW + 17)'(m) << IN_DN) >> IN_UP;
        if (c[MW-1]) begin
            return SW'(-e);
        end
        return (e > (SW + 17)'(MAXP)) ? MAXP : e[SW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] f_sat(input logic signed [LW:0] v);
        logic signed [LW:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[AW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] f_decay(input logic signed [AW-1:0] v);
        logic signed [LW-1:0] x;
        x = LW'(v);
        if (x > DEC) begin
            return AW'(x - DEC);
        end else if (x < -DEC) begin
            return AW'(x + DEC);
        end
        return '0;
    endfunction

    logic signed [16:0]   r_thr, r_prev, r_sin;
    logic signed [17:0]   r_neg;
    logic signed [LW-1:0] r_w, r_prod, r_keep, r_ang;
    logic                 r_hg, r_qt, r_tneg;
    logic [15:0]          r_a, r_x2, r_den, r_rem;
    logic [30:0]          r_num;
    logic [4:0]           r_dcnt;
    logic signed [AW-1:0] r_ia, r_qs;
    logic [SW-1:0]        r_left, r_right;

    logic [14:0]          curve;
    logic [15:0]          thr_mag, gain, sens, alpha, scal, sin_mag;
    logic [LW-1:0]        w_mag, t_mag, p_mag;
    logic signed [LW-1:0] wc, t_src, q_w;
    logic signed [17:0]   one_m_alpha;
    logic [16:0]          rem2, sin_r;
    logic [30:0]          q_c;
    logic                 div_ge;
    logic signed [16:0]   st_db, thr_db;

    logic signed [LW-1:0] m_a, m_res;
    logic signed [17:0]   m_b;
    logic [1:0]           m_sh;
    logic [LW-1:0]        m_am;
    logic [17:0]          m_bm;
    logic [LW+17:0]       m_p, m_ps;

    logic signed [MW-1:0] ang, left, right;

    assign curve       = r_hg ? i_cfg.hi_curve : i_cfg.lo_curve;
    assign thr_mag     = r_thr[16] ? 16'(-r_thr) : 16'(r_thr);
    assign w_mag       = r_w[LW-1] ? LW'(-r_w) : LW'(r_w);
    assign sens        = r_hg ? i_cfg.turn_gains[31:16] : i_cfg.turn_gains[15:0];
    assign alpha       = i_cfg.qs_set[31:16];
    assign scal        = i_cfg.qs_set[15:0];
    assign one_m_alpha = 18'sd32768 - $signed({2'b0, alpha});
    assign wc          = (r_w > ONE) ? ONE : ((r_w < -ONE) ? -ONE : r_w);
    assign sin_mag     = r_sin[16] ? 16'(-r_sin) : 16'(r_sin);
    assign t_src       = i_cmd.pass ? r_prod : LW'({1'b0, curve});
    assign t_mag       = t_src[LW-1] ? LW'(-t_src) : LW'(t_src);
    assign p_mag       = r_prod;
    assign sin_r       = (p_mag > LW'(32768)) ? 17'd32768 : p_mag[16:0];
    assign rem2        = {r_rem, r_num[30]};
    assign div_ge      = rem2 >= {1'b0, r_den};
    assign q_c         = (r_num > 31'd32768) ? 31'd32768 : r_num;
    assign q_w         = r_sin[16] ? -LW'(q_c) : LW'(q_c);
    assign st_db       = f_db(f_in(i_steer), i_cfg.wheel_db);
    assign thr_db      = f_db(f_in(i_throttle), i_cfg.thr_db);

    always_comb begin
        if (r_hg) begin
            gain = i_cfg.inertia_gains[63:48];
        end else if ((r_w > 0 && r_neg > 0) || (r_w < 0 && r_neg < 0)) begin
            gain = i_cfg.inertia_gains[47:32];
        end else if (w_mag > LW'(i_cfg.inertia_thr)) begin
            gain = i_cfg.inertia_gains[31:16];
        end else begin
            gain = i_cfg.inertia_gains[15:0];
        end
    end

    assign o_sts.hg       = r_hg;
    assign o_sts.qt       = r_qt;
    assign o_sts.den_zero = (sin_r == 17'd0);
    assign o_sts.qs_on    = thr_mag < i_cfg.qs_set[47:32];
    assign o_sts.div_last = (r_dcnt == 5'd30);

    // shared multiplier operand select
    always_comb begin
        m_a  = '0;
        m_b  = '0;
        m_sh = SH_15;
        unique case (i_cmd.op)
            ST_SIN_X2:   begin m_a = LW'({1'b0, r_a});  m_b = $signed({2'b0, r_a}); end
            ST_SIN_P1:   begin m_a = r_prod;            m_b = SIN_C5; end
            ST_SIN_P2:   begin m_a = LW'({1'b0, r_x2}); m_b = SIN_C3 - $signed(r_prod[17:0]); end
            ST_SIN_P3:   begin m_a = LW'({1'b0, r_a});  m_b = SIN_C1 - $signed(r_prod[17:0]); end
            ST_PASS_MUL: begin m_a = r_w;               m_b = $signed({3'b0, curve}); end
            ST_IN_MUL:   begin m_a = LW'(r_neg); m_b = $signed({2'b0, gain}); m_sh = SH_11; end
            ST_IN_HALF:  begin m_a = LW'(r_ia);  m_b = 18'sd1; m_sh = SH_1; end
            ST_QS_KEEP:  begin m_a = LW'(r_qs);  m_b = one_m_alpha; end
            ST_QS_WA:    begin m_a = wc;         m_b = $signed({2'b0, alpha}); end
            ST_QS_SC:    begin m_a = r_prod; m_b = $signed({2'b0, scal}); m_sh = SH_11; end
            ST_NT_1:     begin m_a = r_w;        m_b = $signed({2'b0, thr_mag}); end
            ST_NT_2:     begin m_a = r_prod;     m_b = $signed({2'b0, sens}); end
            ST_NT_3:     begin m_a = LW'(r_qs);  m_b = 18'sd1; m_sh = SH_1; end
            default: ;
        endcase
    end

    // sign-magnitude product, truncated toward zero
    always_comb begin
        m_am = m_a[LW-1] ? LW'(-m_a) : LW'(m_a);
        m_bm = m_b[17] ? 18'(-m_b) : 18'(m_b);
        m_p  = (LW + 18)'(m_am) * (LW + 18)'(m_bm);
        case (m_sh)
            SH_11:   m_ps = m_p >> 11;
            SH_1:    m_ps = m_p >> 1;
            default: m_ps = m_p >> 15;
        endcase
        m_res = (m_a[LW-1] ^ m_b[17]) ? -LW'(m_ps) : LW'(m_ps);
    end

    // output mix with over-range handling
    always_comb begin
        ang   = r_qt ? MW'(r_w) : MW'(r_ang);
        left  = MW'(r_thr) + ang;
        right = MW'(r_thr) - ang;
        if (left > ONE_M) begin
            if (r_qt) right = right - (left - ONE_M);
            left = ONE_M;
        end else if (right > ONE_M) begin
            if (r_qt) left = left - (right - ONE_M);
            right = ONE_M;
        end else if (left < -ONE_M) begin
            if (r_qt) right = right + (-ONE_M - left);
            left = -ONE_M;
        end else if (right < -ONE_M) begin
            if (r_qt) left = left + (-ONE_M - right);
            right = -ONE_M;
        end
    end

    assign o_left_power  = r_left;
    assign o_right_power = r_right;

    always_ff @(posedge i_clk) begin
        r_prod <= m_res;
        if (i_cmd.load) begin
            r_thr <= thr_db;
            r_neg <= 18'(st_db) - 18'(r_prev);
            r_w   <= LW'(st_db);
            r_hg  <= i_high_gear;
            r_qt  <= i_quick_turn;
        end
        unique case (i_cmd.op)
            ST_SIN_A: begin
                r_a    <= (t_mag > LW'(32768)) ? 16'd32768 : t_mag[15:0];
                r_tneg <= i_cmd.pass & t_src[LW-1];
            end
            ST_SIN_P1: r_x2 <= r_prod[15:0];
            ST_SIN_R: begin
                if (i_cmd.pass) begin
                    r_sin <= r_tneg ? -$signed(sin_r) : $signed(sin_r);
                end else begin
                    r_den <= sin_r[15:0];
                end
            end
            ST_DIV_LD: begin
                r_num <= {sin_mag, 15'd0};
                r_rem <= '0;
            end
            ST_DIV_STEP: begin
                r_rem <= div_ge ? 16'(rem2 - {1'b0, r_den}) : rem2[15:0];
                r_num <= {r_num[29:0], div_ge};
            end
            ST_DIV_END: r_w    <= q_w;
            ST_QS_WA:   r_keep <= r_prod;
            ST_IN_ADD:  r_w    <= r_w + r_prod;
            ST_NT_3:    r_ang  <= r_prod;
            ST_NT_4:    r_ang  <= r_ang - r_prod;
            ST_MIX: begin
                if (i_cmd.out_we) begin
                    r_left  <= f_out(left);
                    r_right <= f_out(right);
                end
            end
            default: ;
        endcase
    end

    // state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_ia   <= '0;
            r_qs   <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_prev <= st_db;
            end
            if (i_cmd.op == ST_DIV_LD) begin
                r_dcnt <= '0;
            end else if (i_cmd.op == ST_DIV_STEP) begin
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (i_cmd.op == ST_IN_ACC) begin
                r_ia <= f_sat((LW + 1)'(r_ia) + (LW + 1)'(r_prod));
            end else if (i_cmd.op == ST_IN_ADD) begin
                r_ia <= f_decay(r_ia);
            end
            if (i_cmd.op == ST_QS_SUM) begin
                r_qs <= f_sat((LW + 1)'(r_keep) + (LW + 1)'(r_prod));
            end else if (i_cmd.op == ST_NT_4) begin
                r_qs <= f_decay(r_qs);
            end
        end
    end

endmodule

// ===== design/curvature_drive_mixer_unit.sv =====
// Curvature drive mixer top level.
// Turns one throttle/steer request into left and right drive powers. Each request
// runs through one shared multiplier and a one-bit-per-cycle divider: a sine of the
// curve, then per shaping pass a multiply, a sine and a 31-step division (two passes
// in high gear, three in low, none for a zero curve), then the inertia steps
// (multiply, accumulate, halve, add), the turn-power steps if any and a mix step
// that waits for a free output. The next request is taken only after the result
// has gone to the output register.
module curvature_drive_mixer_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCUM_WIDTH  = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdm_cfg_if.sink    i_cfg,
    cdm_in_if.sink     i_in,
    cdm_out_if.source  o_out
);
    import cdm_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready, out_valid;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    cdm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cdm_dp #(
        .SW (SAMPLE_WIDTH),
        .AW (ACCUM_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_throttle    (i_in.throttle),
        .i_steer       (i_in.steer),
        .i_quick_turn  (i_in.quick_turn),
        .i_high_gear   (i_in.high_gear),
        .o_left_power  (o_out.left_power),
        .o_right_power (o_out.right_power)
    );

endmodule
